// ===== rtl/gpm_pkg.sv =====
// ============================================================================
// gpm_pkg: shared types and constants of the glob pattern matcher
// Holds the request and response structs, the decoded pattern element,
// the matcher's control bundles for the element fetcher and the store, and
// the pattern store geometry.
// ============================================================================
`default_nettype none

package gpm_pkg;

   localparam int PATTERN_MAX = 32;
   localparam int ADDR_W      = $clog2(PATTERN_MAX);
   localparam int LEN_W       = $clog2(PATTERN_MAX + 1);
   localparam int POS_CAP     = PATTERN_MAX + 2;
   localparam int POS_W       = $clog2(POS_CAP + 1);

   localparam int FIFO_DEPTH  = 4;
   localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

   localparam logic [1:0] MODE_PATTERN = 2'd0;
   localparam logic [1:0] MODE_TEXT    = 2'd1;
   localparam logic [1:0] MODE_END     = 2'd2;

   localparam logic [7:0] CHAR_ESCAPE  = 8'h5C;
   localparam logic [7:0] CHAR_ANY     = 8'h3F;
   localparam logic [7:0] CHAR_STAR    = 8'h2A;

   typedef enum logic [1:0] {
      KIND_FETCH = 2'd0,
      KIND_STOP  = 2'd1,
      KIND_ALL   = 2'd2
   } kind_type;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] char_byte;
      logic       last;
   } req_type;

   typedef struct packed {
      logic matched;
      logic pattern_overflow;
   } rsp_type;

   typedef struct packed {
      logic [7:0]       elem_byte;
      logic             any_byte;
      kind_type         kind;
      logic [7:0]       stop_byte;
      logic [POS_W-1:0] position;
   } elem_type;

   typedef struct packed {
      logic             restart;
      logic [LEN_W-1:0] length;
   } fetch_ctl_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        data;
   } ram_wr_type;

endpackage

`default_nettype wire

// ===== rtl/gpm_ram.sv =====
// ============================================================================
// gpm_ram: generic single write, single read memory
// One write port and one read port; read data is registered.
// ============================================================================
`default_nettype none

module gpm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/gpm_elem_fetch.sv =====
// ============================================================================
// gpm_elem_fetch: pattern element fetcher
// Walks the pattern store through a four byte window, one position a cycle
// while the window has room, and decodes literal, escape, any-byte and
// star elements, pushing each with the position after it into the queue.
// ============================================================================
`default_nettype none

module gpm_elem_fetch
   import gpm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  fetch_ctl_type     ctl,
   output logic [ADDR_W-1:0] ram_rd_addr,
   input  logic [7:0]        ram_rd_data,
   input  logic              fifo_full,
   output logic              push,
   output elem_type          push_data
);

   logic [LEN_W-1:0] rd_pos_ff, rd_pos_in;
   logic             infl_ff, infl_in;
   logic             infl_zero_ff, infl_zero_in;
   logic [7:0]       win_ff [4];
   logic [7:0]       win_in [4];
   logic [2:0]       win_cnt_ff, win_cnt_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             skip_ff, skip_in;

   logic             fire;
   logic             issue;
   logic             rd_zero;
   logic             adv2;
   logic [2:0]       cnt_keep;
   logic [2:0]       cnt_after;
   logic [7:0]       arr_byte;
   logic [7:0]       look;
   logic [POS_W:0]   pos_sum;
   logic [POS_W-1:0] pos_inc;
   elem_type         elem;

   // decode the element at the window head
   always_comb begin
      elem.elem_byte = win_ff[0];
      elem.any_byte  = 1'b0;
      elem.kind      = KIND_FETCH;
      elem.stop_byte = '0;
      look           = win_ff[1];
      adv2           = 1'b0;
      if (win_ff[0] == CHAR_ESCAPE) begin
         elem.elem_byte = win_ff[1];
         adv2           = 1'b1;
      end else if (win_ff[0] == CHAR_ANY) begin
         elem.elem_byte = '0;
         elem.any_byte  = 1'b1;
      end else if (win_ff[0] == CHAR_STAR) begin
         if (win_ff[1] == CHAR_ESCAPE) begin
            look = win_ff[2];
         end else if (win_ff[1] == CHAR_ANY || win_ff[1] == CHAR_STAR) begin
            look = '0;
         end
         elem.elem_byte = '0;
         elem.any_byte  = 1'b1;
         if (look == '0) begin
            elem.kind = KIND_ALL;
         end else begin
            elem.kind      = KIND_STOP;
            elem.stop_byte = look;
         end
      end
      pos_sum = {1'b0, pos_ff} + (adv2 ? (POS_W+1)'(2) : (POS_W+1)'(1));
      elem.position = (pos_sum > (POS_W+1)'(POS_CAP)) ? POS_W'(POS_CAP)
                                                      : pos_sum[POS_W-1:0];
   end

   always_comb begin
      fire      = (win_cnt_ff >= 3'd3) && (skip_ff || !fifo_full);
      push      = fire && !skip_ff;
      push_data = elem;
      arr_byte  = infl_zero_ff ? 8'd0 : ram_rd_data;
      cnt_keep  = win_cnt_ff - {2'b00, fire};
      cnt_after = cnt_keep + {2'b00, infl_ff};
      issue     = (cnt_after <= 3'd3);
      rd_zero   = (rd_pos_ff >= ctl.length);
      ram_rd_addr = rd_zero ? '0 : rd_pos_ff[ADDR_W-1:0];
      pos_inc   = (pos_ff == POS_W'(POS_CAP)) ? pos_ff : pos_ff + POS_W'(1);

      for (int i = 0; i < 3; i++) begin
         win_in[i] = fire ? win_ff[i+1] : win_ff[i];
      end
      win_in[3] = win_ff[3];
      if (infl_ff) begin
         win_in[cnt_keep[1:0]] = arr_byte;
      end

      win_cnt_in   = cnt_after;
      infl_in      = issue;
      infl_zero_in = rd_zero;
      rd_pos_in    = (issue && rd_pos_ff != LEN_W'(PATTERN_MAX)) ? rd_pos_ff + LEN_W'(1)
                                                                 : rd_pos_ff;
      pos_in       = fire ? pos_inc : pos_ff;
      skip_in      = fire ? (push && win_ff[0] == CHAR_ESCAPE) : skip_ff;

      // restart the walk at position zero
      if (ctl.restart) begin
         win_cnt_in = '0;
         infl_in    = 1'b0;
         rd_pos_in  = '0;
         pos_in     = '0;
         skip_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_pos_ff    <= '0;
         infl_ff      <= 1'b0;
         infl_zero_ff <= 1'b0;
         win_cnt_ff   <= '0;
         pos_ff       <= '0;
         skip_ff      <= 1'b0;
      end else begin
         rd_pos_ff    <= rd_pos_in;
         infl_ff      <= infl_in;
         infl_zero_ff <= infl_zero_in;
         win_cnt_ff   <= win_cnt_in;
         pos_ff       <= pos_in;
         skip_ff      <= skip_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++) begin
         win_ff[i] <= win_in[i];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/gpm_elem_fifo.sv =====
// ============================================================================
// gpm_elem_fifo: decoded element queue
// Short queue of decoded pattern elements between the fetcher and the
// matcher; flush empties it at once.
// ============================================================================
`default_nettype none

module gpm_elem_fifo
   import gpm_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     flush,
   input  logic     push,
   input  elem_type push_data,
   input  logic     pop,
   output logic     full,
   output logic     empty,
   output elem_type head
);

   elem_type               mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0]  cnt_ff, cnt_in;

   always_comb begin
      full  = (cnt_ff == FIFO_CNT_W'(FIFO_DEPTH));
      empty = (cnt_ff == '0);
      head  = mem_ff[rd_ptr_ff];
      if (flush) begin
         wr_ptr_in = '0;
         rd_ptr_in = '0;
         cnt_in    = '0;
      end else begin
         wr_ptr_in = push ? wr_ptr_ff + FIFO_PTR_W'(1) : wr_ptr_ff;
         rd_ptr_in = pop  ? rd_ptr_ff + FIFO_PTR_W'(1) : rd_ptr_ff;
         cnt_in    = cnt_ff + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/gpm_match.sv =====
// ============================================================================
// gpm_match: request intake and text matcher
// Takes pattern, text and end requests, writes pattern bytes into the store,
// steps the non-backtracking star match over text bytes with elements from the
// queue and holds the result in an output register.
// ============================================================================
`default_nettype none

module gpm_match
   import gpm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  req_type       req_data,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output rsp_type       rsp_data,
   input  logic          elem_empty,
   input  elem_type      elem_head,
   output logic          elem_pop,
   output fetch_ctl_type fetch_ctl,
   output ram_wr_type    ram_wr
);

   logic [LEN_W-1:0] len_ff, len_in;
   logic             closed_ff, closed_in;
   logic             ovf_ff, ovf_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       elem_byte_ff, elem_byte_in;
   logic             any_ff, any_in;
   logic [7:0]       stop_byte_ff, stop_byte_in;
   kind_type         kind_ff, kind_in;
   logic             mism_ff, mism_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic             is_pattern;
   logic             is_text;
   logic             is_end;
   logic             emit;
   logic             out_blocked;
   logic             accept;
   logic             need;
   logic [7:0]       t_elem;
   logic             t_any;
   logic [7:0]       t_stop;
   kind_type         t_kind;
   logic [POS_W-1:0] t_pos;
   logic             t_mism;
   logic             e_mism;
   logic [POS_W-1:0] e_pos;
   logic             ok;
   logic [LEN_W-1:0] base_len;
   logic             base_ovf;
   logic             room;
   logic             restart;

   always_comb begin
      is_pattern  = (req_data.mode == MODE_PATTERN);
      is_text     = (req_data.mode == MODE_TEXT);
      is_end      = (req_data.mode == MODE_END);
      emit        = (is_text && req_data.last) || is_end;
      out_blocked = rsp_valid_ff && rsp_stall;
      req_stall   = (is_text && elem_empty) || (emit && out_blocked);
      accept      = req_valid && !req_stall;

      need = !mism_ff && (kind_ff == KIND_FETCH ||
                          (kind_ff == KIND_STOP && stop_byte_ff == req_data.char_byte));
      t_elem = need ? elem_head.elem_byte : elem_byte_ff;
      t_any  = need ? elem_head.any_byte  : any_ff;
      t_stop = need ? elem_head.stop_byte : stop_byte_ff;
      t_kind = need ? elem_head.kind      : kind_ff;
      t_pos  = need ? elem_head.position  : pos_ff;
      t_mism = mism_ff || (!t_any && req_data.char_byte != t_elem);
      if (!mism_ff && t_kind == KIND_FETCH) begin
         t_any = 1'b0;
      end
      elem_pop = accept && is_text && need;

      e_mism = is_text ? t_mism : mism_ff;
      e_pos  = is_text ? t_pos  : pos_ff;
      ok     = !ovf_ff && !e_mism && (e_pos == POS_W'(len_ff));

      base_len = closed_ff ? '0 : len_ff;
      base_ovf = closed_ff ? 1'b0 : ovf_ff;
      room     = (base_len != LEN_W'(PATTERN_MAX));

      ram_wr.en   = accept && is_pattern && room;
      ram_wr.addr = base_len[ADDR_W-1:0];
      ram_wr.data = req_data.char_byte;

      restart           = accept && (is_pattern || emit);
      fetch_ctl.restart = restart;
      fetch_ctl.length  = len_ff;
   end

   always_comb begin
      len_in       = len_ff;
      closed_in    = closed_ff;
      ovf_in       = ovf_ff;
      pos_in       = pos_ff;
      elem_byte_in = elem_byte_ff;
      any_in       = any_ff;
      stop_byte_in = stop_byte_ff;
      kind_in      = kind_ff;
      mism_in      = mism_ff;
      rsp_valid_in = out_blocked;
      rsp_data_in  = rsp_data_ff;

      if (accept) begin
         case (req_data.mode)
            MODE_PATTERN: begin
               len_in    = room ? base_len + LEN_W'(1) : base_len;
               ovf_in    = base_ovf | !room;
               closed_in = req_data.last;
            end
            MODE_TEXT: begin
               closed_in = 1'b1;
               if (!emit) begin
                  pos_in       = t_pos;
                  elem_byte_in = t_elem;
                  any_in       = t_any;
                  stop_byte_in = t_stop;
                  kind_in      = t_kind;
                  mism_in      = t_mism;
               end
            end
            MODE_END: begin
               closed_in = 1'b1;
            end
            default: begin
            end
         endcase
         if (emit) begin
            rsp_valid_in                 = 1'b1;
            rsp_data_in.matched          = ok;
            rsp_data_in.pattern_overflow = ovf_ff;
         end
      end

      // drop match state for the next text
      if (restart) begin
         pos_in       = '0;
         elem_byte_in = '0;
         any_in       = 1'b0;
         stop_byte_in = '0;
         kind_in      = KIND_FETCH;
         mism_in      = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         closed_ff    <= 1'b1;
         ovf_ff       <= 1'b0;
         pos_ff       <= '0;
         elem_byte_ff <= '0;
         any_ff       <= 1'b0;
         stop_byte_ff <= '0;
         kind_ff      <= KIND_FETCH;
         mism_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         closed_ff    <= closed_in;
         ovf_ff       <= ovf_in;
         pos_ff       <= pos_in;
         elem_byte_ff <= elem_byte_in;
         any_ff       <= any_in;
         stop_byte_ff <= stop_byte_in;
         kind_ff      <= kind_in;
         mism_ff      <= mism_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      elem_pop |-> !elem_empty)
      else $error("element popped from empty queue");

   a_ovf_no_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.matched && rsp_data_ff.pattern_overflow))
      else $error("match reported on overflowed pattern");

   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      restart |=> (pos_ff == '0 && !mism_ff && kind_ff == KIND_FETCH))
      else $error("match state not cleared after restart");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_W'(PATTERN_MAX))
      else $error("pattern length beyond store");
`endif

endmodule

`default_nettype wire

// ===== rtl/glob_pattern_matcher_unit.sv =====
// ============================================================================
// glob_pattern_matcher_unit: streaming glob wildcard matcher
// Send a pattern as mode 0 requests (last on its final byte), then text
// bytes as mode 1 requests (last on the final byte), or one mode 2 request
// for an empty text or to end a text early. Each text gives one response
// with matched and pattern_overflow; the pattern stays for further texts.
// Pattern requests are taken one per cycle. Text bytes are taken one per
// cycle while the element queue holds a decoded element; the fetcher
// produces one element per cycle while the queue has room, an escape
// element also taking the step of the byte it escapes. After every pattern
// byte and after every response the fetcher restarts at pattern position 0,
// so the first text byte waits for the store read and three window bytes.
// The response is registered: it is valid the cycle after the final text
// request is accepted. A stalled response holds; a further final request
// is stalled until the response register frees, while other requests go on.
// Reset empties the pattern (length zero) and clears the match state.
// ============================================================================
`default_nettype none

module glob_pattern_matcher_unit
   import gpm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   fetch_ctl_type     fetch_ctl;
   ram_wr_type        ram_wr;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic [7:0]        ram_rd_data;
   logic              fifo_full;
   logic              fifo_empty;
   logic              fifo_push;
   logic              fifo_pop;
   elem_type          fifo_push_data;
   elem_type          fifo_head;

   gpm_ram #(
      .WIDTH (8),
      .DEPTH (PATTERN_MAX)
   ) u_pattern_ram (
      .clock   (clock),
      .wr_en   (ram_wr.en),
      .wr_addr (ram_wr.addr),
      .wr_data (ram_wr.data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   gpm_elem_fetch u_fetch (
      .clock       (clock),
      .reset       (reset),
      .ctl         (fetch_ctl),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .fifo_full   (fifo_full),
      .push        (fifo_push),
      .push_data   (fifo_push_data)
   );

   gpm_elem_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .flush     (fetch_ctl.restart),
      .push      (fifo_push),
      .push_data (fifo_push_data),
      .pop       (fifo_pop),
      .full      (fifo_full),
      .empty     (fifo_empty),
      .head      (fifo_head)
   );

   gpm_match u_match (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .elem_empty (fifo_empty),
      .elem_head  (fifo_head),
      .elem_pop   (fifo_pop),
      .fetch_ctl  (fetch_ctl),
      .ram_wr     (ram_wr)
   );

endmodule

`default_nettype wire
